// ===== src/alc_pkg.sv =====
package alc_pkg;

  // Port and field widths.
  localparam int RAW_W      = 16;
  localparam int LUX_W      = 32;
  localparam int GAIN_W     = 2;
  localparam int TIME_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int MAX_LUX_W  = 18;
  localparam int X_W        = 34;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIME = 1'b1;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 2'd1;
  localparam logic [TIME_W-1:0] TIME_RESET     = 3'd3;
  localparam logic [TIME_W-1:0] LAST_TIME_STEP = 3'd5;

  // Pipeline depth, input register through output register.
  localparam int NUM_STAGES = 17;

  // Resolution scaling: x = round(raw * 42 * 2^(e+16) / 10000). The factor 16
  // of 10000 is folded into the shift, leaving a divide by 625.
  localparam int                COUNT_SCALE    = 42;
  localparam int                RES_SHIFT_BASE = 12;
  localparam int                DIV_BASE       = 625;
  localparam int                ROUND_BIAS     = 312;
  localparam logic [22:0]       RECIP_625      = 23'd6871947;  // floor(2^32 / 625)

  // Correction polynomial coefficients (magnitudes; B is negative).
  localparam logic [19:0] COEF_A     = 20'd693309;      // Q60
  localparam logic [21:0] COEF_B_MAG = 22'd2643726;     // Q48, negative
  localparam logic [18:0] COEF_C     = 19'd349988;      // Q32
  localparam logic [32:0] COEF_D     = 33'd4304845721;  // Q32

  // Smallest entry of the maximum-lux table.
  localparam int MIN_MAX_LUX = 275;

  function automatic logic [2:0] gain_shift(input logic [GAIN_W-1:0] g);
    logic [2:0] sh;
    case (g)
      2'd0:    sh = 3'd0;
      2'd1:    sh = 3'd1;
      2'd2:    sh = 3'd3;
      2'd3:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [MAX_LUX_W-1:0] max_lux_lookup(input logic [TIME_W-1:0] t,
                                                          input logic [GAIN_W-1:0] g);
    logic [4*MAX_LUX_W-1:0] row;
    case (t)
      3'd0:    row = {18'd4404,   18'd2202,  18'd550,   18'd275};
      3'd1:    row = {18'd8808,   18'd4404,  18'd1101,  18'd550};
      3'd2:    row = {18'd17616,  18'd8808,  18'd2202,  18'd1101};
      3'd3:    row = {18'd35232,  18'd17616, 18'd4404,  18'd2202};
      3'd4:    row = {18'd70463,  18'd35232, 18'd8808,  18'd4404};
      default: row = {18'd140926, 18'd70463, 18'd17616, 18'd8808};
    endcase
    return row[g*MAX_LUX_W +: MAX_LUX_W];
  endfunction

endpackage

// ===== src/ambient_light_lux_converter_top.sv =====
// Ambient light lux converter. Each accepted request carries one raw 16-bit
// light count; one result comes back for each request, in order, holding the
// corrected illuminance as unsigned Q28.4 lux (saturating at all ones) in
// out_tdata and the over-range flag in out_tuser. The count is scaled by the
// resolution of the gain and integration-time steps held in the two
// configuration registers, which are sampled when the request is accepted,
// and then passes through a cubic correction polynomial evaluated by Horner's
// rule. The datapath is a 17-stage pipeline, and a new count is taken every
// cycle while the output register is empty or out_tready is high. The whole
// pipeline advances together, so out_tready low while a result waits holds
// every stage and drops in_tready; the rate is set only by how often the sink
// takes results.
// Integration-time steps six and seven behave as step five.
module ambient_light_lux_converter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [alc_pkg::RAW_W-1:0]         in_tdata,    // [15:0] raw_count
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [alc_pkg::LUX_W-1:0]         out_tdata,   // [31:0] lux_value
  output logic [0:0]                        out_tuser,   // [0] over_range
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import alc_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_step_r;
  logic [TIME_W-1:0] time_step_r;

  // One valid bit per stage; bit NUM_STAGES is the output register.
  logic [NUM_STAGES:1] vld_r;
  logic                adv;

  // Values carried down the pipeline, indexed by the stage that holds them.
  logic [MAX_LUX_W-1:0] mx_r   [1:NUM_STAGES-1];
  logic [4:0]           s_r    [1:5];
  logic [12:0]          q0_r   [3:5];
  logic [X_W-1:0]       x_r    [6:14];
  logic                 neg1_r [8:10];
  logic                 neg2_r [11:13];

  // Stage registers and their next values.
  logic [21:0] c_s1_r,    c_s1_nxt;
  logic [21:0] c_s2_r;
  logic [12:0] q0e_s2_r,  q0e_s2_nxt;
  logic [9:0]  r0_s3_r,   r0_s3_nxt;
  logic [12:0] q0_s3_nxt;
  logic [30:0] v_s4_r,    v_s4_nxt;
  logic [30:0] v_s5_r;
  logic [21:0] q1e_s5_r,  q1e_s5_nxt;
  logic [X_W-1:0] x_s6_nxt;
  logic [53:0] pa_s7_r,   pa_s7_nxt;
  logic [26:0] mag1_s8_r, mag1_s8_nxt;
  logic        neg1_s8_nxt;
  logic [43:0] pl1_s9_r,  pl1_s9_nxt;
  logic [43:0] ph1_s9_r,  ph1_s9_nxt;
  logic [28:0] rm2_s10_r, rm2_s10_nxt;
  logic [29:0] mag2_s11_r, mag2_s11_nxt;
  logic        neg2_s11_nxt;
  logic [46:0] pl2_s12_r, pl2_s12_nxt;
  logic [46:0] ph2_s12_r, ph2_s12_nxt;
  logic [47:0] rm3_s13_r, rm3_s13_nxt;
  logic [48:0] u_s14_r,   u_s14_nxt;
  logic [41:0] pll_s15_r, pll_s15_nxt;
  logic [41:0] plh_s15_r, plh_s15_nxt;
  logic [40:0] phl_s15_r, phl_s15_nxt;
  logic [40:0] phh_s15_r, phh_s15_nxt;
  logic [38:0] lux_s16_r, lux_s16_nxt;
  logic [LUX_W-1:0] lux_out_r, lux_out_nxt;
  logic        over_r,    over_nxt;

  // Combinational intermediates.
  logic [TIME_W-1:0]    t_clamp;
  logic [MAX_LUX_W-1:0] mx_s1_nxt;
  logic [4:0]           s_s1_nxt;
  logic [44:0]          q0_prod;
  logic [21:0]          r0_raw;
  logic                 r0_fix;
  logic [53:0]          q1_prod;
  logic [30:0]          r1_raw;
  logic                 r1_fix;
  logic [21:0]          q1;
  logic [26:0]          t1_raw;
  logic [60:0]          sum2;
  logic [63:0]          sum3;
  logic [82:0]          sum4;
  logic [39:0]          lux_ceil_sum;
  logic [35:0]          lux_ceil;

  // Configuration writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_step_r <= GAIN_RESET;
      time_step_r <= TIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_GAIN: gain_step_r <= cfg_wdata[GAIN_W-1:0];
        CFG_IDX_TIME: time_step_r <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register is free or
  // its result is being taken in this cycle.
  assign adv        = !vld_r[NUM_STAGES] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NUM_STAGES];
  assign out_tdata  = lux_out_r;
  assign out_tuser  = over_r;

  // Stage 1: scale the count by 42 and form the total shift and the
  // maximum-lux threshold for the current configuration.
  assign t_clamp   = (time_step_r > LAST_TIME_STEP) ? LAST_TIME_STEP : time_step_r;
  assign c_s1_nxt  = 22'(in_tdata) * 22'(COUNT_SCALE);
  assign s_s1_nxt  = 5'(t_clamp) + 5'(gain_shift(gain_step_r)) + 5'(RES_SHIFT_BASE);
  assign mx_s1_nxt = max_lux_lookup(t_clamp, gain_step_r);

  // Stages 2 and 3: split the scaled count into quotient and remainder by
  // 625. The reciprocal estimate is low by at most one.
  assign q0_prod    = 45'(c_s1_r) * 45'(RECIP_625);
  assign q0e_s2_nxt = q0_prod[44:32];
  assign r0_raw     = c_s2_r - 22'(q0e_s2_r) * 22'(DIV_BASE);
  assign r0_fix     = r0_raw >= 22'(DIV_BASE);
  assign q0_s3_nxt  = q0e_s2_r + 13'(r0_fix);
  assign r0_s3_nxt  = r0_fix ? 10'(r0_raw - 22'(DIV_BASE)) : 10'(r0_raw);

  // Stages 4 to 6: divide the shifted remainder (with the rounding bias) by
  // 625 the same way, then rebuild x in Q18.16.
  assign v_s4_nxt   = (31'(r0_s3_r) << s_r[3]) + 31'(ROUND_BIAS);
  assign q1_prod    = 54'(v_s4_r) * 54'(RECIP_625);
  assign q1e_s5_nxt = q1_prod[53:32];
  assign r1_raw     = v_s5_r - 31'(q1e_s5_r) * 31'(DIV_BASE);
  assign r1_fix     = r1_raw >= 31'(DIV_BASE);
  assign q1         = q1e_s5_r + 22'(r1_fix);
  assign x_s6_nxt   = (X_W'(q0_r[5]) << s_r[5]) + X_W'(q1);

  // Stages 7 and 8: t1 = round(A*x / 2^28) + B, kept as sign and magnitude.
  assign pa_s7_nxt   = 54'(x_r[6]) * 54'(COEF_A);
  assign t1_raw      = 27'(pa_s7_r[53:28]) + 27'(pa_s7_r[27]);
  assign neg1_s8_nxt = t1_raw < 27'(COEF_B_MAG);
  assign mag1_s8_nxt = neg1_s8_nxt ? 27'(COEF_B_MAG) - t1_raw : t1_raw - 27'(COEF_B_MAG);

  // Stages 9 to 11: t2 = round(t1*x / 2^32) + C, rounding the magnitude so
  // that ties go away from zero.
  assign pl1_s9_nxt  = 44'(mag1_s8_r) * 44'(x_r[8][16:0]);
  assign ph1_s9_nxt  = 44'(mag1_s8_r) * 44'(x_r[8][33:17]);
  assign sum2        = 61'(pl1_s9_r) + (61'(ph1_s9_r) << 17) + (61'(1) << 31);
  assign rm2_s10_nxt = sum2[60:32];

  always_comb begin
    if (neg1_r[10]) begin
      neg2_s11_nxt = rm2_s10_r > 29'(COEF_C);
      mag2_s11_nxt = neg2_s11_nxt ? 30'(rm2_s10_r - 29'(COEF_C))
                                  : 30'(29'(COEF_C) - rm2_s10_r);
    end else begin
      neg2_s11_nxt = 1'b0;
      mag2_s11_nxt = 30'(rm2_s10_r) + 30'(COEF_C);
    end
  end

  // Stages 12 to 14: t3 = round(t2*x / 2^16) + D, clamped at zero.
  assign pl2_s12_nxt = 47'(mag2_s11_r) * 47'(x_r[11][16:0]);
  assign ph2_s12_nxt = 47'(mag2_s11_r) * 47'(x_r[11][33:17]);
  assign sum3        = 64'(pl2_s12_r) + (64'(ph2_s12_r) << 17) + (64'(1) << 15);
  assign rm3_s13_nxt = sum3[63:16];

  always_comb begin
    if (!neg2_r[13]) begin
      u_s14_nxt = 49'(rm3_s13_r) + 49'(COEF_D);
    end else if (rm3_s13_r > 48'(COEF_D)) begin
      u_s14_nxt = '0;
    end else begin
      u_s14_nxt = 49'(48'(COEF_D) - rm3_s13_r);
    end
  end

  // Stages 15 and 16: lux in Q4 = round(t3*x / 2^44), from four partial
  // products summed in the next stage.
  assign pll_s15_nxt = 42'(u_s14_r[24:0])  * 42'(x_r[14][16:0]);
  assign plh_s15_nxt = 42'(u_s14_r[24:0])  * 42'(x_r[14][33:17]);
  assign phl_s15_nxt = 41'(u_s14_r[48:25]) * 41'(x_r[14][16:0]);
  assign phh_s15_nxt = 41'(u_s14_r[48:25]) * 41'(x_r[14][33:17]);
  assign sum4        = 83'(pll_s15_r) + (83'(plh_s15_r) << 17) + (83'(phl_s15_r) << 25)
                     + (83'(phh_s15_r) << 42) + (83'(1) << 43);
  assign lux_s16_nxt = sum4[82:44];

  // Stage 17: the flag compares the rounded-up lux before saturation.
  assign lux_ceil_sum = 40'(lux_s16_r) + 40'(15);
  assign lux_ceil     = lux_ceil_sum[39:4];
  assign over_nxt     = lux_ceil >= 36'(mx_r[NUM_STAGES-1]);
  assign lux_out_nxt  = (|lux_s16_r[38:32]) ? '1 : lux_s16_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-1:1], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r[1] <= mx_s1_nxt;
      for (int k = 2; k <= NUM_STAGES - 1; k++) begin
        mx_r[k] <= mx_r[k-1];
      end
      s_r[1] <= s_s1_nxt;
      for (int k = 2; k <= 5; k++) begin
        s_r[k] <= s_r[k-1];
      end
      q0_r[3] <= q0_s3_nxt;
      q0_r[4] <= q0_r[3];
      q0_r[5] <= q0_r[4];
      x_r[6]  <= x_s6_nxt;
      for (int k = 7; k <= 14; k++) begin
        x_r[k] <= x_r[k-1];
      end
      neg1_r[8]  <= neg1_s8_nxt;
      neg1_r[9]  <= neg1_r[8];
      neg1_r[10] <= neg1_r[9];
      neg2_r[11] <= neg2_s11_nxt;
      neg2_r[12] <= neg2_r[11];
      neg2_r[13] <= neg2_r[12];

      c_s1_r     <= c_s1_nxt;
      c_s2_r     <= c_s1_r;
      q0e_s2_r   <= q0e_s2_nxt;
      r0_s3_r    <= r0_s3_nxt;
      v_s4_r     <= v_s4_nxt;
      v_s5_r     <= v_s4_r;
      q1e_s5_r   <= q1e_s5_nxt;
      pa_s7_r    <= pa_s7_nxt;
      mag1_s8_r  <= mag1_s8_nxt;
      pl1_s9_r   <= pl1_s9_nxt;
      ph1_s9_r   <= ph1_s9_nxt;
      rm2_s10_r  <= rm2_s10_nxt;
      mag2_s11_r <= mag2_s11_nxt;
      pl2_s12_r  <= pl2_s12_nxt;
      ph2_s12_r  <= ph2_s12_nxt;
      rm3_s13_r  <= rm3_s13_nxt;
      u_s14_r    <= u_s14_nxt;
      pll_s15_r  <= pll_s15_nxt;
      plh_s15_r  <= plh_s15_nxt;
      phl_s15_r  <= phl_s15_nxt;
      phh_s15_r  <= phh_s15_nxt;
      lux_s16_r  <= lux_s16_nxt;
      lux_out_r  <= lux_out_nxt;
      over_r     <= over_nxt;
    end
  end

  // The corrected remainder of the first divide by 625 is always in range.
  a_r0_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (r0_s3_r < 10'(DIV_BASE)))
    else $error("remainder after divide by 625 out of range");

  // A request in the last inner stage reaches the output when the pipeline moves.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_STAGES-1] && adv) |=> out_tvalid)
    else $error("result lost between the last two stages");

  // Over-range needs at least the smallest table entry in lux.
  a_over_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata >= 32'(16 * MIN_MAX_LUX - 15)))
    else $error("over-range flag raised on a small lux value");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Stream-level test of the lux converter. Requests are raw light counts fed from a
// queue by a clocked driver; every accepted request is run through an independent
// fixed-point model of the resolution scaling and the cubic correction. The modeled
// result is queued, and a clocked monitor checks each returned result against the
// oldest queued one. The run walks through many gain and integration-time settings,
// the extremes included, and randomly stalls both sides of the block.
module tb_top;
  import alc_pkg::*;

  // One modeled result: corrected lux (Q28.4) and the over-range flag.
  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic             over;
  } lux_result_t;

  // Correction polynomial in fixed point: A Q60, B Q48, C Q32, D Q32.
  localparam longint POLY_A = 64'sd693309;
  localparam longint POLY_B = -64'sd2643726;
  localparam longint POLY_C = 64'sd349988;
  localparam longint POLY_D = 64'sd4304845721;

  // The sink's one long hold-off, in cycles. It is much deeper than the pipeline,
  // so the block must fill up and drop in_tready while the driver keeps offering.
  localparam int SINK_HOLD_CYCLES = 300;

  // Longest stretch without any handshake before the run is declared hung. The
  // slowest legal stretch is the long hold-off plus a random stall and the latency.
  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [RAW_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [LUX_W-1:0]      out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Counts waiting to be offered, and results expected back, oldest first.
  logic [RAW_W-1:0] raw_pending_q[$];
  lux_result_t      lux_expect_q[$];

  // Local copy of the two configuration registers, as the block holds them.
  logic [GAIN_W-1:0] gain_q = GAIN_RESET;
  logic [TIME_W-1:0] tstep_q = TIME_RESET;

  bit offering;         // driver has a request on the bus
  bit idle_on;          // random gaps on both sides for the current phase
  bit sink_hold_req;    // ask the monitor for its one long hold-off
  bit sink_hold_done;
  int src_gap;
  int sink_stall;
  int quiet_cycles;
  int mismatch_cnt;

  ambient_light_lux_converter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // v * x / 2^k rounded to nearest with ties away from zero. The product is taken
  // on the magnitude so that negative terms round symmetrically.
  function automatic longint round_shift(longint v, logic [63:0] x, int unsigned k);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag  = (v < 0) ? -v : v;
    prod = ({64'd0, mag} * {64'd0, x} + (128'd1 << (k - 1))) >> k;
    return (v < 0) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // Maximum lux of a setting, before the over-range flag is raised.
  function automatic int unsigned lux_ceiling(int unsigned ts, logic [GAIN_W-1:0] gain);
    int unsigned row [4];
    case (ts)
      0:       row = '{275, 550, 2202, 4404};
      1:       row = '{550, 1101, 4404, 8808};
      2:       row = '{1101, 2202, 8808, 17616};
      3:       row = '{2202, 4404, 17616, 35232};
      4:       row = '{4404, 8808, 35232, 70463};
      default: row = '{8808, 17616, 70463, 140926};
    endcase
    return row[gain];
  endfunction

  // Full conversion of one count under the given setting.
  function automatic lux_result_t predict_lux(logic [RAW_W-1:0] raw, logic [GAIN_W-1:0] gain,
                                              logic [TIME_W-1:0] tstep);
    int unsigned  ts;
    int unsigned  gsh;
    logic [63:0]  raw64;
    logic [63:0]  x;
    longint       t1;
    longint       t2;
    longint       t3;
    logic [127:0] wide;
    logic [63:0]  q4;
    lux_result_t  r;
    // Integration-time steps past the last one behave as the last one.
    ts = 32'((tstep > LAST_TIME_STEP) ? LAST_TIME_STEP : tstep);
    case (gain)
      2'd0:    gsh = 0;
      2'd1:    gsh = 1;
      2'd2:    gsh = 3;
      default: gsh = 4;
    endcase
    // Uncorrected lux in Q16: raw * 0.0042 * 2^(ts + gsh), rounded half up.
    raw64 = 64'(raw);
    x = (raw64 * 64'd42 * (64'd1 << (ts + gsh + 16)) + 64'd5000) / 64'd10000;
    // Horner evaluation of the correction polynomial.
    t1 = round_shift(POLY_A, x, 28) + POLY_B;
    t2 = round_shift(t1, x, 32) + POLY_C;
    t3 = round_shift(t2, x, 16) + POLY_D;
    if (t3 < 0) begin
      t3 = 0;
    end
    // Q32 * Q16 down to Q4, rounded half up.
    wide = {64'd0, t3} * {64'd0, x};
    wide = (wide + (128'd1 << 43)) >> 44;
    q4   = wide[63:0];
    // The flag uses the unsaturated value rounded up to whole lux.
    r.over = (((q4 + 64'd15) >> 4) >= 64'(lux_ceiling(ts, gain)));
    r.lux  = (q4 > 64'hFFFF_FFFF) ? '1 : q4[LUX_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) begin
      $display("%0t ERROR %s", $time, msg);
    end
  endtask

  // A register write takes effect at the edge where cfg_we is seen high. Writes are
  // only issued while nothing is in flight, so the model copy can follow at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_GAIN) begin
      gain_q = val[GAIN_W-1:0];
    end else begin
      tstep_q = val[TIME_W-1:0];
    end
  endtask

  // Wait until every queued count has been taken and every result has come back.
  task automatic drain();
    while (raw_pending_q.size() != 0 || offering || lux_expect_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: offers queued counts. A request stays on the bus until accepted; the
  // model result is queued at the accepting edge with the setting in force then.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      offering  = 1'b0;
      src_gap   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        lux_expect_q.push_back(predict_lux(in_tdata, gain_q, tstep_q));
        offering = 1'b0;
      end
      if (!offering) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (raw_pending_q.size() != 0) begin
          in_tdata  <= raw_pending_q.pop_front();
          in_tvalid <= 1'b1;
          offering  = 1'b1;
          src_gap   = idle_on ? draw_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation, and
  // drives out_tready with random stalls plus the one long hold-off.
  always @(posedge clk) begin
    lux_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (lux_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with no request outstanding",
                                    out_tdata, out_tuser));
        end else begin
          exp_r = lux_expect_q.pop_front();
          if (out_tdata !== exp_r.lux) begin
            report_mismatch($sformatf("lux_value %h, expected %h", out_tdata, exp_r.lux));
          end
          if (out_tuser[0] !== exp_r.over) begin
            report_mismatch($sformatf("over_range %b, expected %b (lux %h)",
                                      out_tuser[0], exp_r.over, exp_r.lux));
          end
        end
      end
      if (sink_hold_req && !sink_hold_done) begin
        sink_stall     = SINK_HOLD_CYCLES;
        sink_hold_done = 1'b1;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        sink_stall = idle_on ? draw_gap() : 0;
      end
    end
  end

  // Watchdog: any stretch without a handshake on either side longer than the
  // limit means the block has hung or lost results.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ambient_light_lux_converter_top test failed");
        $finish;
      end
    end
  end

  initial begin
    int          sel;
    logic [15:0] cnt;
    logic [3:0]  phase_v;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset setting (gain 1, 100 ms): zero, one, full
    // scale, the sign-like top bit and alternating bit patterns.
    idle_on = 1'b0;
    raw_pending_q.push_back(16'h0000);
    raw_pending_q.push_back(16'h0001);
    raw_pending_q.push_back(16'hFFFF);
    raw_pending_q.push_back(16'h8000);
    raw_pending_q.push_back(16'h7FFF);
    raw_pending_q.push_back(16'hAAAA);
    raw_pending_q.push_back(16'h5555);
    drain();

    // Finest resolution: gain 2, 800 ms. Full scale lands far over range.
    write_reg(CFG_IDX_GAIN, 3'd0);
    write_reg(CFG_IDX_TIME, 3'd0);
    raw_pending_q.push_back(16'hFFFF);
    raw_pending_q.push_back(16'h0001);
    raw_pending_q.push_back(16'h00FF);
    raw_pending_q.push_back(16'h1000);
    drain();

    // Coarsest legal resolution: gain one eighth, 25 ms. The gain write carries
    // an extra high bit that the register must drop.
    write_reg(CFG_IDX_GAIN, 3'b111);
    write_reg(CFG_IDX_TIME, 3'd5);
    raw_pending_q.push_back(16'hFFFF);
    raw_pending_q.push_back(16'h0000);
    raw_pending_q.push_back(16'h0100);
    drain();

    // Integration-time steps six and seven must behave as step five.
    write_reg(CFG_IDX_TIME, 3'd6);
    raw_pending_q.push_back(16'hFFFF);
    raw_pending_q.push_back(16'h1234);
    drain();
    write_reg(CFG_IDX_TIME, 3'd7);
    raw_pending_q.push_back(16'hFFFF);
    raw_pending_q.push_back(16'h0001);
    raw_pending_q.push_back(16'hC000);
    drain();

    // Random part: sixteen phases sweep every gain step and every time-step code,
    // about seventy counts each. Odd phases idle at random on both sides, even
    // phases run back to back.
    for (int phase = 0; phase < 16; phase++) begin
      phase_v = 4'(phase);
      write_reg(CFG_IDX_GAIN, {1'($urandom_range(0, 1)), phase_v[1:0]});
      write_reg(CFG_IDX_TIME, phase_v[3:1]);
      idle_on = phase_v[0];
      // In one back-to-back phase the sink holds off long enough to fill the
      // pipeline and push back on the driver.
      if (phase == 6) begin
        sink_hold_req = 1'b1;
      end
      for (int n = 0; n < 70; n++) begin
        // Halfway through one phase the driver pauses until all results are back.
        if (phase == 9 && n == 35) begin
          drain();
        end
        sel = $urandom_range(0, 9);
        case (sel)
          0, 1, 2, 3, 4: cnt = 16'($urandom_range(0, 65535));
          5, 6:          cnt = 16'($urandom_range(0, 255));
          7:             cnt = 16'($urandom_range(16'hF000, 16'hFFFF));
          8:             cnt = 16'd1 << $urandom_range(0, 15);
          default:       cnt = 16'($urandom_range(0, 4095));
        endcase
        raw_pending_q.push_back(cnt);
      end
      drain();
    end

    // Let the pipeline run out, then make sure nothing further shows up.
    repeat (NUM_STAGES + 8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ambient_light_lux_converter_top test passed");
    end else begin
      $display("ambient_light_lux_converter_top test failed");
    end
    $finish;
  end

endmodule
